// ----- hdl/npcm_pkg.sv -----
`default_nettype none

package npcm_pkg;

  // Request codes carried by req_type
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_RANGE_START = 2'd0;
  localparam logic [1:0] CFG_RANGE_END   = 2'd1;
  localparam logic [1:0] CFG_SEARCH_MODE = 2'd2;
  localparam logic [1:0] CFG_MAX_SLOTS   = 2'd3;

  // Register reset values
  localparam logic [7:0]  RST_RANGE_START = 8'd0;
  localparam logic [8:0]  RST_RANGE_END   = 9'd256;
  localparam logic        RST_SEARCH_MODE = 1'b1;
  localparam logic [16:0] RST_MAX_SLOTS   = 17'd256;

  // Channel weights, squared luma coefficients
  localparam logic [11:0] W_GREEN = 12'd3481;
  localparam logic [11:0] W_RED   = 12'd900;
  localparam logic [11:0] W_BLUE  = 12'd121;

  // Luma coefficients
  localparam logic [6:0] L_RED   = 7'd30;
  localparam logic [6:0] L_GREEN = 7'd59;
  localparam logic [6:0] L_BLUE  = 7'd11;

  // floor(x / 25) for x < 2**14 as (x * RECIP_25) >> RECIP_SHIFT
  localparam logic [14:0] RECIP_25    = 15'd20972;
  localparam int          RECIP_SHIFT = 19;

  // Empty search range answer
  localparam logic [8:0] EMPTY_SEARCH_IDX = 9'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RAMP_MUL,
    ST_RAMP_DIV,
    ST_RAMP_SUM,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/nearest_palette_color_match.sv -----
`default_nettype none

// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | req_type, restart, entry_index, red, green, blue
// out     | output    | out_valid_o/out_ready_i | best_index, slot, full_res
// cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One word at a time. A load leaves the block idle and ready. A search match
// walks span = end - start entries through the single palette read port, one
// entry per cycle, then through the distance pipeline. A ramp match steps through
// the multiply, divide and sum states; a full match or empty-range search skips to result.
// The input is taken again as soon as the result sits in the output register,
// even while that word stalls.
// Reset clears the slot counter and valid flags and restores the configuration
// registers to their reset values; palette contents stay undefined until loaded.
module nearest_palette_color_match #(
  parameter int NUM_ENTRIES = 256
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_ready_o,
  input  wire  logic        req_type_i,
  input  wire  logic        restart_i,
  input  wire  logic [7:0]  entry_index_i,
  input  wire  logic [7:0]  red_i,
  input  wire  logic [7:0]  green_i,
  input  wire  logic [7:0]  blue_i,
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output logic [7:0]        best_index_o,
  output logic [15:0]       slot_o,
  output logic              full_res_o,
  input  wire  logic        cfg_we_i,
  input  wire  logic [1:0]  cfg_idx_i,
  input  wire  logic [16:0] cfg_data_i
);
  import npcm_pkg::*;

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  state_e state_q, state_d;

  logic [7:0]  range_start_q;
  logic [8:0]  range_end_q;
  logic        search_mode_q;
  logic [16:0] max_slots_q;
  logic [16:0] count_q, count_d;

  logic [23:0] pal_mem [NUM_ENTRIES];
  logic [23:0] rdata_q;

  logic [7:0]  qr_q, qg_q, qb_q;
  logic [8:0]  scan_q;
  logic [8:0]  best_q;
  logic [20:0] lowest_q;
  logic        res_full_q;
  logic [15:0] res_slot_q;

  logic        p1_vld_q, p2_vld_q, p3_vld_q;
  logic [8:0]  p1_idx_q, p2_idx_q, p3_idx_q;
  logic [15:0] sq_r_q, sq_g_q, sq_b_q;
  logic [19:0] term_r_q, term_g_q, term_b_q;

  logic [14:0] luma_q;
  logic [8:0]  span_q;
  logic [23:0] prod_q;
  logic [9:0]  quo_q;

  logic        out_valid_q;
  logic [7:0]  out_idx_q;
  logic [15:0] out_slot_q;
  logic        out_full_q;

  logic        acc, acc_ld, acc_mt, is_full, issue_rd, ld_out;
  logic [8:0]  end_eff, span_w;
  logic [14:0] luma_w;
  logic [7:0]  d_r, d_g, d_b;
  logic [27:0] wt_r, wt_g, wt_b;
  logic [20:0] dist_sum;
  logic [28:0] recip_prod;
  logic [9:0]  ramp_sum;

  // Effective end and span, query luma
  always_comb begin
    end_eff = ({4'b0, range_end_q} > 13'(NUM_ENTRIES)) ? 9'(NUM_ENTRIES) : range_end_q;
    span_w  = (end_eff > {1'b0, range_start_q}) ? (end_eff - {1'b0, range_start_q}) : 9'd0;
    luma_w  = 15'(red_i) * 15'(L_RED) + 15'(green_i) * 15'(L_GREEN)
            + 15'(blue_i) * 15'(L_BLUE);
  end

  assign acc     = in_valid_i && in_ready_o;
  assign acc_ld  = acc && (req_type_i == REQ_LOAD);
  assign acc_mt  = acc && (req_type_i == REQ_MATCH);
  assign is_full = !restart_i && (count_q >= max_slots_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_mt) begin
          if (is_full) begin
            state_d = ST_RESULT;
          end else if (search_mode_q) begin
            state_d = (span_w != 9'd0) ? ST_SCAN : ST_RESULT;
          end else begin
            state_d = ST_RAMP_MUL;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q == end_eff - 9'd1) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_vld_q && !p2_vld_q && !p3_vld_q) state_d = ST_RESULT;
      end
      ST_RAMP_MUL: state_d = ST_RAMP_DIV;
      ST_RAMP_DIV: state_d = ST_RAMP_SUM;
      ST_RAMP_SUM: state_d = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue_rd   = 1'b0;
    ld_out     = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN:   issue_rd   = 1'b1;
      ST_RESULT: ld_out     = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  // Slot counter
  always_comb begin
    count_d = count_q;
    if (acc_mt && !is_full) count_d = (restart_i ? 17'd0 : count_q) + 17'd1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      range_start_q <= RST_RANGE_START;
      range_end_q   <= RST_RANGE_END;
      search_mode_q <= RST_SEARCH_MODE;
      max_slots_q   <= RST_MAX_SLOTS;
      p1_vld_q      <= 1'b0;
      p2_vld_q      <= 1'b0;
      p3_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      p1_vld_q <= issue_rd;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RANGE_START: range_start_q <= cfg_data_i[7:0];
          CFG_RANGE_END:   range_end_q   <= cfg_data_i[8:0];
          CFG_SEARCH_MODE: search_mode_q <= cfg_data_i[0];
          CFG_MAX_SLOTS:   max_slots_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Palette memory: write on load, registered read during scan
  always_ff @(posedge clk_i) begin
    if (acc_ld && (13'(entry_index_i) < 13'(NUM_ENTRIES))) begin
      pal_mem[AW'(entry_index_i)] <= {red_i, green_i, blue_i};
    end
    if (issue_rd) rdata_q <= pal_mem[AW'(scan_q)];
  end

  // Distance pipeline and ramp arithmetic
  always_comb begin
    d_r = (qr_q >= rdata_q[23:16]) ? (qr_q - rdata_q[23:16]) : (rdata_q[23:16] - qr_q);
    d_g = (qg_q >= rdata_q[15:8])  ? (qg_q - rdata_q[15:8])  : (rdata_q[15:8] - qg_q);
    d_b = (qb_q >= rdata_q[7:0])   ? (qb_q - rdata_q[7:0])   : (rdata_q[7:0] - qb_q);
    wt_r = 28'(sq_r_q) * 28'(W_RED);
    wt_g = 28'(sq_g_q) * 28'(W_GREEN);
    wt_b = 28'(sq_b_q) * 28'(W_BLUE);
    dist_sum = 21'(term_r_q) + 21'(term_g_q) + 21'(term_b_q);
    recip_prod = 29'(prod_q[23:10]) * 29'(RECIP_25);
    ramp_sum = 10'(range_start_q) + quo_q;
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    // Capture query and result setup on a match; step the scan address on each read
    if (acc_mt) begin
      qr_q     <= red_i;
      qg_q     <= green_i;
      qb_q     <= blue_i;
      luma_q   <= luma_w;
      span_q   <= span_w;
      scan_q   <= {1'b0, range_start_q};
      lowest_q <= '1;
      if (is_full) begin
        res_full_q <= 1'b1;
        res_slot_q <= '0;
        best_q     <= '0;
      end else begin
        res_full_q <= 1'b0;
        res_slot_q <= restart_i ? 16'd0 : count_q[15:0];
        best_q     <= EMPTY_SEARCH_IDX;
      end
    end else if (issue_rd) begin
      scan_q <= scan_q + 9'd1;
    end

    // Stage 1: squared differences
    p1_idx_q <= scan_q;
    sq_r_q   <= 16'(d_r) * 16'(d_r);
    sq_g_q   <= 16'(d_g) * 16'(d_g);
    sq_b_q   <= 16'(d_b) * 16'(d_b);
    p2_idx_q <= p1_idx_q;
    // Stage 2: weighted terms, floored
    term_r_q <= wt_r[27:8];
    term_g_q <= wt_g[27:8];
    term_b_q <= wt_b[27:8];
    p3_idx_q <= p2_idx_q;

    // Stage 3: keep first strict minimum
    if (p3_vld_q && (dist_sum < lowest_q)) begin
      best_q   <= p3_idx_q;
      lowest_q <= dist_sum;
    end

    // Ramp: luma * span, divide by 25600, add range start, clamp to 255
    if (state_q == ST_RAMP_MUL) prod_q <= 24'(luma_q) * 24'(span_q);
    if (state_q == ST_RAMP_DIV) quo_q <= recip_prod[28:RECIP_SHIFT];
    if (state_q == ST_RAMP_SUM) best_q <= (ramp_sum > 10'd255) ? 9'd255 : ramp_sum[8:0];

    // Output register
    if (ld_out) begin
      out_idx_q  <= (best_q > 9'd255) ? 8'd255 : best_q[7:0];
      out_slot_q <= res_slot_q;
      out_full_q <= res_full_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_index_o = out_idx_q;
  assign slot_o       = out_slot_q;
  assign full_res_o   = out_full_q;

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q < end_eff))
    else $error("scan address past effective end");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_res_o) |-> (best_index_o == 8'd0 && slot_o == 16'd0))
    else $error("full result carries index or slot");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |-> (!p1_vld_q && !p2_vld_q && !p3_vld_q))
    else $error("result taken with distance pipeline busy");

  a_lowest_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_vld_q |=> (lowest_q <= $past(lowest_q)))
    else $error("best distance grew during search");
`endif

endmodule

`default_nettype wire
